// ----- design/grid_rect_first_fit_allocator_assert.svh -----
// Assertion macros for the grid rectangle allocator.
// Included by the controller and datapath; empty bodies under SYNTHESIS.
`ifndef GRID_RECT_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define GRID_RECT_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define GRFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GRFA_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRFA_ASSERT(lbl, clk, rst_n, prop, msg)
`define GRFA_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ----- design/grfa_pkg.sv -----
// Shared types and constants of the grid rectangle allocator.
// No dependencies; used by every module of the block but grfa_ram.
`default_nettype none

package grfa_pkg;

    localparam int OP_W   = 2;
    localparam int SIZE_W = 5;
    localparam int POS_W  = 4;
    localparam int CFG_W  = 5;
    localparam int IDX_W  = 2;

    localparam int DEF_MAX_COLUMNS = 16;
    localparam int DEF_MAX_ROWS    = 16;

    localparam logic [CFG_W-1:0] GRID_RESET = 5'd16;

    localparam logic [IDX_W-1:0] CFG_IDX_COLS = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_ROWS = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_FIRST_FIT = 2'd0,
        OP_ALLOC_AT  = 2'd1,
        OP_FREE      = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef struct packed {
        logic load;
        logic start_scan;
        logic start_check;
        logic start_write;
        logic step;
        logic scan;
        logic check;
        logic write;
        logic set_fail;
        logic set_zero;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic zero_size;
        logic fits_at;
        logic rows_left;
        logic pipe_busy;
        logic hit;
        logic clash;
    } t_sts;

endpackage

`default_nettype wire

// ----- design/grfa_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module grfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/grfa_ctrl.sv -----
// Request sequencer of the grid rectangle allocator.
// Depends on grfa_pkg and grid_rect_first_fit_allocator_assert.svh.
`default_nettype none
`include "grid_rect_first_fit_allocator_assert.svh"

module grfa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire grfa_pkg::t_sts  i_sts,
    output grfa_pkg::t_cmd       o_cmd,
    output logic                 o_res_strobe
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_SCAN     = 6'b000100,
        S_CHECK    = 6'b001000,
        S_WRITE    = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state         r_state;
    t_state         n_state;
    grfa_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    grfa_pkg::OP_FIRST_FIT: begin
                        if (i_sts.zero_size) begin
                            cmd.set_zero = 1'b1;
                            n_state      = S_DONE;
                        end else begin
                            cmd.start_scan = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end
                    grfa_pkg::OP_ALLOC_AT: begin
                        if (i_sts.fits_at) begin
                            cmd.start_check = 1'b1;
                            n_state         = S_CHECK;
                        end else begin
                            cmd.set_fail = 1'b1;
                            n_state      = S_DONE;
                        end
                    end
                    grfa_pkg::OP_FREE: begin
                        cmd.start_write = 1'b1;
                        n_state         = S_WRITE;
                    end
                    grfa_pkg::OP_NONE: begin
                        cmd.set_fail = 1'b1;
                        n_state      = S_DONE;
                    end
                    default: begin
                        cmd.set_fail = 1'b1;
                        n_state      = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    cmd.start_write = 1'b1;
                    n_state         = S_WRITE;
                end else if (!i_sts.rows_left && !i_sts.pipe_busy) begin
                    cmd.set_fail = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (!i_sts.rows_left && !i_sts.pipe_busy) begin
                    if (i_sts.clash) begin
                        cmd.set_fail = 1'b1;
                        n_state      = S_DONE;
                    end else begin
                        cmd.start_write = 1'b1;
                        n_state         = S_WRITE;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_WRITE: begin
                cmd.write = 1'b1;
                if (!i_sts.rows_left && !i_sts.pipe_busy) begin
                    n_state = S_DONE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd        = cmd;
    assign busy         = (r_state != S_IDLE);
    assign o_res_strobe = (r_state == S_DONE);

    `GRFA_ASSERT(a_strobe_single, i_clk, i_rst_n, o_res_strobe |=> !o_res_strobe, "result strobe longer than one cycle")
    `GRFA_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "request accepted but block not busy")
    `GRFA_ASSERT(a_strobe_idle, i_clk, i_rst_n, o_res_strobe |=> !busy, "block still busy after result")
    `GRFA_ASSERT_NORST(a_reset_idle, i_clk, !i_rst_n |=> !busy, "block busy after reset")

endmodule

`default_nettype wire

// ----- design/grfa_dp.sv -----
// Datapath of the grid rectangle allocator: grid registers, row bitmap RAM,
// column free-height scan, window search and read-modify-write of rows.
// Depends on grfa_pkg, grfa_ram and grid_rect_first_fit_allocator_assert.svh.
`default_nettype none
`include "grid_rect_first_fit_allocator_assert.svh"

module grfa_dp #(
    parameter int MAX_COLUMNS = grfa_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = grfa_pkg::DEF_MAX_ROWS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire grfa_pkg::t_cmd                i_cmd,
    output grfa_pkg::t_sts                     o_sts,
    input  wire logic [grfa_pkg::OP_W-1:0]     i_operation,
    input  wire logic [grfa_pkg::SIZE_W-1:0]   i_size_x,
    input  wire logic [grfa_pkg::SIZE_W-1:0]   i_size_y,
    input  wire logic [grfa_pkg::POS_W-1:0]    i_pos_x,
    input  wire logic [grfa_pkg::POS_W-1:0]    i_pos_y,
    input  wire logic                          i_cfg_we,
    input  wire logic [grfa_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [grfa_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                               o_success,
    output logic      [grfa_pkg::POS_W-1:0]    o_placed_x,
    output logic      [grfa_pkg::POS_W-1:0]    o_placed_y
);

    localparam int MAXD = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int CNTW = $clog2(MAXD + 48);
    localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int XW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int SZW  = grfa_pkg::SIZE_W;
    localparam logic [SZW-1:0] HMAX = '1;

    // clamp a grid register to 1..maxv
    function automatic logic [CNTW-1:0] eff_dim(input logic [grfa_pkg::CFG_W-1:0] v,
                                                input int unsigned maxv);
        logic [CNTW-1:0] e;
        e = CNTW'(v);
        if (v == '0) begin
            e = CNTW'(1);
        end else if (e > CNTW'(maxv)) begin
            e = CNTW'(maxv);
        end
        return e;
    endfunction

    // columns x..x+w-1 that lie below cols
    function automatic logic [MAX_COLUMNS-1:0] span(input logic [CNTW-1:0] x,
                                                    input logic [CNTW-1:0] w,
                                                    input logic [CNTW-1:0] cols);
        logic [MAX_COLUMNS-1:0] m;
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            m[c] = (CNTW'(c) >= x) && (CNTW'(c) < x + w) && (CNTW'(c) < cols);
        end
        return m;
    endfunction

    // bit x set when a[x..x+w-1] are all set; built from doubling spans
    function automatic logic [MAX_COLUMNS-1:0] win_fit(input logic [MAX_COLUMNS-1:0] a,
                                                       input logic [SZW-1:0] w);
        logic [MAX_COLUMNS-1:0] cur;
        logic [MAX_COLUMNS-1:0] res;
        logic                   first;
        cur   = a;
        res   = '0;
        first = 1'b1;
        for (int b = 0; b < SZW; b++) begin
            if (w[b]) begin
                res   = first ? cur : (cur & (res >> (1 << b)));
                first = 1'b0;
            end
            cur = cur & (cur >> (1 << b));
        end
        return res;
    endfunction

    logic [grfa_pkg::CFG_W-1:0] r_grid_cols;
    logic [grfa_pkg::CFG_W-1:0] r_grid_rows;

    grfa_pkg::t_op          r_op;
    logic [SZW-1:0]         r_w;
    logic [SZW-1:0]         r_h;
    logic [grfa_pkg::POS_W-1:0] r_px;
    logic [grfa_pkg::POS_W-1:0] r_py;
    logic [CNTW-1:0]        r_cols;
    logic [CNTW-1:0]        r_rows;

    logic [CNTW-1:0]        r_row;
    logic [CNTW-1:0]        r_end;
    logic [MAX_COLUMNS-1:0] r_mask;
    logic                   r_set;
    logic                   r_clash;

    logic                   r_rv;
    logic [RW-1:0]          r_raddr;
    logic                   r_rvld;
    logic [MAX_ROWS-1:0]    r_vld;

    logic [SZW-1:0]         r_hgt [MAX_COLUMNS];
    logic                   r_hv;
    logic [RW-1:0]          r_hrow;
    logic [MAX_COLUMNS-1:0] r_win;
    logic                   r_wv;
    logic [RW-1:0]          r_wrow;

    logic                       r_ok;
    logic [grfa_pkg::POS_W-1:0] r_ox;
    logic [grfa_pkg::POS_W-1:0] r_oy;

    logic [CNTW-1:0]        w_e;
    logic [CNTW-1:0]        h_e;
    logic [CNTW-1:0]        px_e;
    logic [CNTW-1:0]        py_e;
    logic                   rows_left;
    logic                   any_start;
    logic                   rd_en;
    logic [RW-1:0]          rd_addr;
    logic [MAX_COLUMNS-1:0] ram_rdata;
    logic [MAX_COLUMNS-1:0] rowdat;
    logic                   ram_we;
    logic [MAX_COLUMNS-1:0] ram_wdata;
    logic [MAX_COLUMNS-1:0] avail;
    logic [XW-1:0]          hit_x;
    logic [CNTW-1:0]        hit_y;
    logic                   hit;
    logic [CNTW-1:0]        sel_x;
    logic [CNTW-1:0]        sel_y;
    logic [CNTW-1:0]        free_end;
    logic [CNTW-1:0]        wr_end;

    assign w_e       = CNTW'(r_w);
    assign h_e       = CNTW'(r_h);
    assign px_e      = CNTW'(r_px);
    assign py_e      = CNTW'(r_py);
    assign rows_left = (r_row < r_end);
    assign any_start = i_cmd.start_scan || i_cmd.start_check || i_cmd.start_write;
    assign rd_en     = i_cmd.step && rows_left;
    assign rd_addr   = r_row[RW-1:0];
    assign rowdat    = r_rvld ? ram_rdata : '0;
    assign ram_we    = i_cmd.write && r_rv;
    assign ram_wdata = r_set ? (rowdat | r_mask) : (rowdat & ~r_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= grfa_pkg::GRID_RESET;
            r_grid_rows <= grfa_pkg::GRID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                grfa_pkg::CFG_IDX_COLS: r_grid_cols <= i_cfg_data;
                grfa_pkg::CFG_IDX_ROWS: r_grid_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= grfa_pkg::t_op'(i_operation);
            r_w    <= i_size_x;
            r_h    <= i_size_y;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_cols <= eff_dim(r_grid_cols, MAX_COLUMNS);
            r_rows <= eff_dim(r_grid_rows, MAX_ROWS);
        end
    end

    // write-phase selection
    assign hit_y    = CNTW'(r_wrow) + CNTW'(1) - h_e;
    assign hit      = r_wv && (|r_win);
    assign sel_x    = (r_op == grfa_pkg::OP_FIRST_FIT) ? CNTW'(hit_x) : px_e;
    assign sel_y    = (r_op == grfa_pkg::OP_FIRST_FIT) ? hit_y : py_e;
    assign free_end = (py_e + h_e > r_rows) ? r_rows : (py_e + h_e);
    assign wr_end   = (r_op == grfa_pkg::OP_FREE) ? free_end : (sel_y + h_e);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_end <= '0;
        end else if (i_cmd.start_scan) begin
            r_row <= '0;
            r_end <= r_rows;
        end else if (i_cmd.start_check) begin
            r_row <= py_e;
            r_end <= py_e + h_e;
        end else if (i_cmd.start_write) begin
            r_row <= sel_y;
            r_end <= wr_end;
        end else if (rd_en) begin
            r_row <= r_row + CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_check) begin
            r_mask <= span(px_e, w_e, r_cols);
        end else if (i_cmd.start_write) begin
            r_mask <= span(sel_x, w_e, r_cols);
            r_set  <= (r_op != grfa_pkg::OP_FREE);
        end
        if (i_cmd.start_check) begin
            r_clash <= 1'b0;
        end else if (i_cmd.check && r_rv && (|(rowdat & r_mask))) begin
            r_clash <= 1'b1;
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else begin
            r_rv <= !any_start && rd_en;
        end
        r_raddr <= rd_addr;
        r_rvld  <= r_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ram_we) begin
            r_vld[r_raddr] <= 1'b1;
        end
    end

    grfa_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (MAX_ROWS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_raddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // free-height per column, counted over scanned rows
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            if (i_cmd.start_scan || (i_cmd.scan && r_rv && rowdat[c])) begin
                r_hgt[c] <= '0;
            end else if (i_cmd.scan && r_rv && (r_hgt[c] != HMAX)) begin
                r_hgt[c] <= r_hgt[c] + SZW'(1);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            avail[c] = (r_hgt[c] >= r_h) && (CNTW'(c) < r_cols);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_wv <= 1'b0;
        end else begin
            r_hv <= !any_start && i_cmd.scan && r_rv;
            r_wv <= !any_start && i_cmd.scan && r_hv;
        end
        r_hrow <= r_raddr;
        r_wrow <= r_hrow;
        r_win  <= win_fit(avail, r_w);
    end

    always_comb begin
        hit_x = '0;
        for (int c = MAX_COLUMNS - 1; c >= 0; c--) begin
            if (r_win[c]) begin
                hit_x = XW'(c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_fail) begin
            r_ok <= 1'b0;
            r_ox <= '0;
            r_oy <= '0;
        end else if (i_cmd.set_zero) begin
            r_ok <= (w_e <= r_cols) && (h_e <= r_rows);
            r_ox <= '0;
            r_oy <= '0;
        end else if (i_cmd.start_write) begin
            r_ok <= 1'b1;
            r_ox <= sel_x[grfa_pkg::POS_W-1:0];
            r_oy <= sel_y[grfa_pkg::POS_W-1:0];
        end
    end

    assign o_success  = r_ok;
    assign o_placed_x = r_ox;
    assign o_placed_y = r_oy;

    always_comb begin
        o_sts           = '0;
        o_sts.op        = r_op;
        o_sts.zero_size = (r_w == '0) || (r_h == '0);
        o_sts.fits_at   = (px_e + w_e <= r_cols) && (py_e + h_e <= r_rows);
        o_sts.rows_left = rows_left;
        o_sts.pipe_busy = r_rv || r_hv || r_wv;
        o_sts.hit       = hit;
        o_sts.clash     = r_clash;
    end

    `GRFA_ASSERT(a_wr_in_grid, i_clk, i_rst_n, ram_we |-> (CNTW'(r_raddr) < r_rows), "row off grid")
    `GRFA_ASSERT(a_hit_in_grid, i_clk, i_rst_n, hit |-> (hit_y + h_e <= r_rows), "hit off grid")

endmodule

`default_nettype wire

// ----- design/grid_rect_first_fit_allocator.sv -----
// First-fit rectangle allocator on a row bitmap grid, with allocate-at and free.
// First-fit scans from row 0 and writes the first window that fits; a zero size
// skips the scan. Allocate-at fails out of bounds, else checks its rows and
// writes them unless they clash. Free clears the rows it touches. One request
// at a time: the next start is taken the cycle after the strobe; results are never held.
// Synchronous reset frees every cell (per-row valid flags), sets grid to 16x16.
`default_nettype none

module grid_rect_first_fit_allocator #(
    parameter int MAX_COLUMNS = grfa_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = grfa_pkg::DEF_MAX_ROWS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [grfa_pkg::OP_W-1:0]     i_operation,
    input  wire logic [grfa_pkg::SIZE_W-1:0]   i_size_x,
    input  wire logic [grfa_pkg::SIZE_W-1:0]   i_size_y,
    input  wire logic [grfa_pkg::POS_W-1:0]    i_pos_x,
    input  wire logic [grfa_pkg::POS_W-1:0]    i_pos_y,
    output logic                               o_res_strobe,
    output logic                               o_success,
    output logic      [grfa_pkg::POS_W-1:0]    o_placed_x,
    output logic      [grfa_pkg::POS_W-1:0]    o_placed_y,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [grfa_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [grfa_pkg::CFG_W-1:0]    i_cfg_data
);

    grfa_pkg::t_cmd cmd;
    grfa_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    grfa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_res_strobe (o_res_strobe)
    );

    grfa_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_operation),
        .i_size_x    (i_size_x),
        .i_size_y    (i_size_y),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_success   (o_success),
        .o_placed_x  (o_placed_x),
        .o_placed_y  (o_placed_y)
    );

endmodule

`default_nettype wire
